### design/mips_r3000_subset_core_unit_defines.svh
// Assertion macros used by the core's top-level checking code.
`ifndef MIPS_R3000_SUBSET_CORE_UNIT_DEFINES_SVH
`define MIPS_R3000_SUBSET_CORE_UNIT_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define MRC_ASSERT_IMPLY(lbl, clk, rstn, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define MRC_ASSERT_NEXT(lbl, clk, rstn, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);
`endif

### design/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Types, codes and helpers shared by the MIPS subset core.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam int unsigned REG_COUNT_DEF = 32;
    localparam logic [31:0] RESET_PC_DEF = 32'hBFC0_0000;
    localparam logic [31:0] GPR_RESET_VAL = 32'hBEBE_BEBE;
    localparam logic [4:0] STATUS_IDX = 5'd12;
    localparam logic [4:0] LINK_IDX = 5'h1F;

    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] LD_LB = 2'd0;
    localparam logic [1:0] LD_LBU = 2'd1;
    localparam logic [1:0] LD_LW = 2'd2;

    localparam logic [2:0] HALT_NONE = 3'd0;
    localparam logic [2:0] HALT_UNHANDLED = 3'd1;
    localparam logic [2:0] HALT_OVERFLOW = 3'd2;
    localparam logic [2:0] HALT_COPROC = 3'd3;
    localparam logic [2:0] HALT_PROTECT = 3'd4;
    localparam logic [2:0] HALT_DIVIDE = 3'd5;

    localparam logic [0:0] KIND_INSTR = 1'b0;
    localparam logic [0:0] KIND_LOAD = 1'b1;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [31:0] instruction_word;
        logic [31:0] load_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic [1:0]  mem_request;
        logic [31:0] mem_address;
        logic [1:0]  mem_size;
        logic [31:0] mem_write_data;
        logic [31:0] status_word;
        logic [2:0]  halt_cause;
    } out_item_t;

    // queue status reported by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic is_protected(input logic [4:0] r);
        is_protected = (r == 5'd3) || (r == 5'd5) || (r == 5'd6) ||
                       (r == 5'd7) || (r == 5'd9) || (r == 5'd11);
    endfunction

endpackage

### design/mips_r3000_subset_core_unit.sv
// An accepted transaction is registered in the input queue and then in the
// result register; one transaction per cycle while the result side accepts.
// The next PC and register writes are combinational, so items stream
// back to back; a two-entry input queue absorbs result-side stalls.
// Reset (aresetn low, synchronous) loads PC 0xBFC00000, clears COP0, halt and
// load state; general registers read 0xBEBEBEBE until written, r0 reads zero.
// ----------------------------------------------------------------------------
// mips_r3000_subset_core_unit
// Top level: input queue feeding the MIPS subset execute unit.
// ----------------------------------------------------------------------------
`include "mips_r3000_subset_core_unit_defines.svh"
module mips_r3000_subset_core_unit #(
    parameter int unsigned REG_COUNT = mrc_pkg::REG_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  mrc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mrc_pkg::out_item_t m_data
);
    logic              q_valid, q_take, halted;
    mrc_pkg::in_item_t q_data;
    mrc_pkg::q_stat_t  q_stat;

    // front: hold incoming transactions while the back stalls
    mrc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data), .q_stat(q_stat)
    );

    // back: execute one transaction per cycle into the result register, unless the result side stalls
    mrc_back #(.REG_COUNT(REG_COUNT)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .halted(halted)
    );

    `MRC_ASSERT_IMPLY(a_full_stalls, aclk, aresetn, q_stat.full, !s_ready, "full queue took input")
    `MRC_ASSERT_IMPLY(a_empty_idle, aclk, aresetn, q_stat.empty, !q_valid, "empty queue offered item")
    `MRC_ASSERT_NEXT(a_halt_sticks, aclk, aresetn, halted, halted, "halt flag cleared")
endmodule

### design/mrc_front.sv
// ----------------------------------------------------------------------------
// mrc_front
// Input side: two-entry queue that takes transactions while the back is busy.
// ----------------------------------------------------------------------------
module mrc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mrc_pkg::in_item_t s_data,
    output logic              q_valid,
    input  logic              q_take,
    output mrc_pkg::in_item_t q_data,
    output mrc_pkg::q_stat_t  q_stat
);
    mrc_pkg::in_item_t buf_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_take;
    assign q_data = buf_reg[rp_reg];
    assign q_stat.full = (cnt_reg == 2'd2);
    assign q_stat.empty = (cnt_reg == 2'd0);

    always_comb begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wp_reg] <= s_data;
        end
    end
endmodule

### design/mrc_back.sv
// ----------------------------------------------------------------------------
// mrc_back
// Execute side: register files, PC, delay slot, load delay, result register.
// ----------------------------------------------------------------------------
module mrc_back #(
    parameter int unsigned REG_COUNT = mrc_pkg::REG_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               q_valid,
    output logic               q_take,
    input  mrc_pkg::in_item_t  q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mrc_pkg::out_item_t m_data,
    output logic               halted
);
    localparam int unsigned IW = $clog2(REG_COUNT);

    logic [31:0] gpr_reg [REG_COUNT];
    logic [REG_COUNT-1:0] gwr_reg;
    logic [31:0] cop_reg [REG_COUNT];
    logic [31:0] pc_reg, pc_next;
    logic [31:0] held_reg;
    logic [IW-1:0] dlt_reg, dlt_next;
    logic [31:0] dlv_reg, dlv_next;
    logic halt_reg, halt_next;
    logic [2:0] hc_reg, hc_next;
    logic lo_reg, lo_next;
    logic [1:0] lk_reg, lk_next;
    logic [IW-1:0] lt_reg, lt_next;
    logic mv_reg;
    mrc_pkg::out_item_t out_reg, out_next;

    logic [31:0] ins, a, b, simm, imm, s, d, pc4, btgt;
    logic [5:0] op, fn;
    logic [IW-1:0] rs, rt, rd;
    logic [4:0] sh;
    logic [IW-1:0] wr_reg;
    logic [31:0] wr_val;
    logic cop_we;
    logic step, is_instr;

    assign q_take = !mv_reg || m_ready;
    assign step = q_valid && q_take;
    assign is_instr = (q_data.opcode == mrc_pkg::KIND_INSTR);
    assign m_valid = mv_reg;
    assign m_data = out_reg;
    assign halted = halt_reg;

    assign ins = held_reg;
    assign op = ins[31:26];
    assign rs = ins[21+:IW];
    assign rt = ins[16+:IW];
    assign rd = ins[11+:IW];
    assign sh = ins[10:6];
    assign fn = ins[5:0];
    assign imm = {16'd0, ins[15:0]};
    assign simm = mrc_pkg::sext16(ins[15:0]);
    assign a = (rs == '0) ? 32'd0 : (gwr_reg[rs] ? gpr_reg[rs] : mrc_pkg::GPR_RESET_VAL);
    assign b = (rt == '0) ? 32'd0 : (gwr_reg[rt] ? gpr_reg[rt] : mrc_pkg::GPR_RESET_VAL);
    assign pc4 = pc_reg + 32'd4;
    assign btgt = pc_reg + {simm[29:0], 2'b00};

    always_comb begin
        pc_next = pc_reg;
        dlt_next = dlt_reg;
        dlv_next = dlv_reg;
        halt_next = halt_reg;
        hc_next = hc_reg;
        lo_next = lo_reg;
        lk_next = lk_reg;
        lt_next = lt_reg;
        wr_reg = '0;
        wr_val = 32'd0;
        cop_we = 1'b0;
        s = 32'd0;
        d = q_data.load_data;
        out_next = '0;
        if (!halt_reg && !is_instr) begin
            if (lo_reg) begin
                case (lk_reg)
                    mrc_pkg::LD_LB: d = {{24{q_data.load_data[7]}}, q_data.load_data[7:0]};
                    mrc_pkg::LD_LBU: d = {24'd0, q_data.load_data[7:0]};
                    default: d = q_data.load_data;
                endcase
                dlt_next = lt_reg;
                dlv_next = d;
                lo_next = 1'b0;
            end
        end else if (!halt_reg) begin
            lo_next = 1'b0;
            pc_next = pc4;
            dlt_next = '0;
            dlv_next = 32'd0;
            unique case (op)
                6'h00: begin
                    unique case (fn)
                        6'h00: begin wr_reg = rd; wr_val = b << sh; end
                        6'h03: begin wr_reg = rd; wr_val = $signed(b) >>> sh; end
                        6'h08: pc_next = a;
                        6'h09: begin wr_reg = rd; wr_val = pc4; pc_next = a; end
                        6'h1A: begin halt_next = 1'b1; hc_next = mrc_pkg::HALT_DIVIDE; end
                        6'h20: begin
                            s = a + b;
                            if (((a ^ s) & (b ^ s)) >> 31 != 32'd0) begin
                                halt_next = 1'b1;
                                hc_next = mrc_pkg::HALT_OVERFLOW;
                            end else begin
                                wr_reg = rd;
                                wr_val = s;
                            end
                        end
                        6'h21: begin wr_reg = rd; wr_val = a + b; end
                        6'h23: begin wr_reg = rd; wr_val = a - b; end
                        6'h24: begin wr_reg = rd; wr_val = a & b; end
                        6'h25: begin wr_reg = rd; wr_val = a | b; end
                        6'h2B: begin wr_reg = rd; wr_val = {31'd0, a < b}; end
                        default: begin halt_next = 1'b1; hc_next = mrc_pkg::HALT_UNHANDLED; end
                    endcase
                end
                6'h01: begin
                    if (ins[20]) begin
                        wr_reg = IW'(mrc_pkg::LINK_IDX);
                        wr_val = pc4;
                    end
                    if (ins[16] ? !a[31] : a[31]) pc_next = btgt;
                end
                6'h02, 6'h03: begin
                    if (op == 6'h03) begin
                        wr_reg = IW'(mrc_pkg::LINK_IDX);
                        wr_val = pc4;
                    end
                    pc_next = {pc_reg[31:28], ins[25:0], 2'b00};
                end
                6'h04: if (a == b) pc_next = btgt;
                6'h05: if (a != b) pc_next = btgt;
                6'h06: if (a[31] || a == 32'd0) pc_next = btgt;
                6'h07: if (!a[31] && a != 32'd0) pc_next = btgt;
                6'h08: begin
                    s = a + simm;
                    if (((a ^ s) & (simm ^ s)) >> 31 != 32'd0) begin
                        halt_next = 1'b1;
                        hc_next = mrc_pkg::HALT_OVERFLOW;
                    end else begin
                        wr_reg = rt;
                        wr_val = s;
                    end
                end
                6'h09: begin wr_reg = rt; wr_val = a + simm; end
                6'h0A: begin wr_reg = rt; wr_val = {31'd0, $signed(a) < $signed(simm)}; end
                6'h0C: begin wr_reg = rt; wr_val = a & imm; end
                6'h0D: begin wr_reg = rt; wr_val = a | imm; end
                6'h0F: begin wr_reg = rt; wr_val = {ins[15:0], 16'd0}; end
                6'h10: begin
                    if (ins[25:21] == 5'h04 || ins[25:21] == 5'h00) begin
                        if (ins[1:0] != 2'd0) begin
                            halt_next = 1'b1;
                            hc_next = mrc_pkg::HALT_COPROC;
                        end else if (ins[25:21] == 5'h04) begin
                            if (rd != '0) begin
                                cop_we = 1'b1;
                                if (b != 32'd0 && mrc_pkg::is_protected(ins[15:11])) begin
                                    halt_next = 1'b1;
                                    hc_next = mrc_pkg::HALT_PROTECT;
                                end
                            end
                        end else begin
                            dlt_next = rt;
                            dlv_next = cop_reg[rd];
                        end
                    end else begin
                        pc_next = pc_reg;
                        halt_next = 1'b1;
                        hc_next = mrc_pkg::HALT_UNHANDLED;
                    end
                end
                6'h20, 6'h23, 6'h24: begin
                    out_next.mem_request = mrc_pkg::REQ_READ;
                    out_next.mem_address = a + simm;
                    out_next.mem_size = (op == 6'h23) ? mrc_pkg::SIZE_WORD : mrc_pkg::SIZE_BYTE;
                    lo_next = 1'b1;
                    lk_next = (op == 6'h20) ? mrc_pkg::LD_LB :
                              ((op == 6'h24) ? mrc_pkg::LD_LBU : mrc_pkg::LD_LW);
                    lt_next = rt;
                end
                6'h28, 6'h29, 6'h2B: begin
                    out_next.mem_request = mrc_pkg::REQ_WRITE;
                    out_next.mem_address = a + simm;
                    out_next.mem_size = (op == 6'h28) ? mrc_pkg::SIZE_BYTE :
                        ((op == 6'h29) ? mrc_pkg::SIZE_HALF : mrc_pkg::SIZE_WORD);
                    out_next.mem_write_data = (op == 6'h28) ? {24'd0, b[7:0]} :
                        ((op == 6'h29) ? {16'd0, b[15:0]} : b);
                    out_next.status_word = cop_reg[IW'(mrc_pkg::STATUS_IDX)];
                end
                default: begin
                    pc_next = pc_reg;
                    halt_next = 1'b1;
                    hc_next = mrc_pkg::HALT_UNHANDLED;
                end
            endcase
        end
        out_next.fetch_address = pc_next;
        out_next.halt_cause = hc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= mrc_pkg::RESET_PC_DEF;
            held_reg <= 32'd0;
            dlt_reg <= '0;
            dlv_reg <= 32'd0;
            halt_reg <= 1'b0;
            hc_reg <= mrc_pkg::HALT_NONE;
            lo_reg <= 1'b0;
            lk_reg <= mrc_pkg::LD_LB;
            lt_reg <= '0;
            mv_reg <= 1'b0;
            gwr_reg <= '0;
        end else begin
            if (cfg_we) begin
                pc_reg <= cfg_wdata;
            end else if (step) begin
                pc_reg <= pc_next;
            end
            if (step) begin
                if (!halt_reg && is_instr) begin
                    held_reg <= q_data.instruction_word;
                    if (dlt_reg != '0) gwr_reg[dlt_reg] <= 1'b1;
                    if (wr_reg != '0) gwr_reg[wr_reg] <= 1'b1;
                end
                dlt_reg <= dlt_next;
                dlv_reg <= dlv_next;
                halt_reg <= halt_next;
                hc_reg <= hc_next;
                lo_reg <= lo_next;
                lk_reg <= lk_next;
                lt_reg <= lt_next;
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // register files: the instruction's own write wins over the load commit
    always_ff @(posedge aclk) begin
        if (step && !halt_reg && is_instr) begin
            if (dlt_reg != '0) gpr_reg[dlt_reg] <= dlv_reg;
            if (wr_reg != '0) gpr_reg[wr_reg] <= wr_val;
        end
        if (step) out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) cop_reg[i] <= 32'd0;
        end else if (step && !halt_reg && is_instr && cop_we) begin
            cop_reg[rd] <= b;
        end
    end
endmodule

### sim/mips_r3000_subset_core_unit_test.sv
// ----------------------------------------------------------------------------
// mips_r3000_subset_core_unit_test
// Self-checking bench for the MIPS R3000 subset core: a cycle-free predictor
// of the instruction stream is compared with every result the core returns.
// ----------------------------------------------------------------------------
module mips_r3000_subset_core_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_BAD     = 6'h3F;
    // SPECIAL function codes.
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_SLTU = 6'h2B;
    // COP0 move selectors (rs field).
    localparam logic [4:0] CP_MF = 5'h00;
    localparam logic [4:0] CP_MT = 5'h04;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    // ------------------------------------------------------------------
    // Architectural predictor plus the queue of results still owed.
    // ------------------------------------------------------------------
    class core_result_board;
        logic [31:0] gpr[32];
        logic [31:0] cop0[32];
        logic [31:0] boot_pc, pc, held, dl_val;
        logic [4:0]  dl_tgt, ld_tgt;
        logic [1:0]  ld_kind;
        logic        halted, ld_busy;
        logic [2:0]  cause;
        mrc_pkg::out_item_t pending_results[$];
        int          errors;

        function new();
            for (int i = 0; i < 32; i++) begin
                gpr[i] = mrc_pkg::GPR_RESET_VAL;
                cop0[i] = '0;
            end
            gpr[0] = '0;
            boot_pc = mrc_pkg::RESET_PC_DEF;
            pc = boot_pc;
            held = '0;
            dl_tgt = '0;
            dl_val = '0;
            halted = 1'b0;
            ld_busy = 1'b0;
            ld_kind = '0;
            ld_tgt = '0;
            cause = mrc_pkg::HALT_NONE;
            errors = 0;
        endfunction

        function void load_boot_pc(logic [31:0] v);
            boot_pc = v;
            pc = v;
        endfunction

        function void stop(logic [2:0] c);
            halted = 1'b1;
            cause = c;
        endfunction

        // Advance the core by one transaction and return what it must report.
        function mrc_pkg::out_item_t execute_item(mrc_pkg::in_item_t it);
            mrc_pkg::out_item_t r;
            logic [31:0] ins, a, b, simm, s, wr_val, d;
            logic [5:0]  op, fn;
            logic [4:0]  rs, rt, rd, sh, wr_reg;
            r = '0;
            if (!halted && it.opcode == mrc_pkg::KIND_LOAD) begin
                if (ld_busy) begin
                    d = it.load_data;
                    if (ld_kind == mrc_pkg::LD_LB) d = {{24{d[7]}}, d[7:0]};
                    else if (ld_kind == mrc_pkg::LD_LBU) d = {24'd0, d[7:0]};
                    dl_tgt = ld_tgt;
                    dl_val = d;
                    ld_busy = 1'b0;
                end
            end else if (!halted) begin
                ins = held;
                ld_busy = 1'b0;
                held = it.instruction_word;
                pc = pc + 32'd4;
                op = ins[31:26];
                rs = ins[25:21];
                rt = ins[20:16];
                rd = ins[15:11];
                sh = ins[10:6];
                fn = ins[5:0];
                simm = {{16{ins[15]}}, ins[15:0]};
                a = gpr[rs];
                b = gpr[rt];
                wr_reg = '0;
                wr_val = '0;
                // commit the delayed load after operands were read
                if (dl_tgt != 0) gpr[dl_tgt] = dl_val;
                dl_tgt = '0;
                dl_val = '0;
                case (op)
                    OP_SPECIAL: begin
                        case (fn)
                            FN_SLL:  begin wr_reg = rd; wr_val = b << sh; end
                            FN_SRA:  begin wr_reg = rd; wr_val = $signed(b) >>> sh; end
                            FN_JR:   pc = a;
                            FN_JALR: begin wr_reg = rd; wr_val = pc; pc = a; end
                            FN_DIV:  stop(mrc_pkg::HALT_DIVIDE);
                            FN_ADD: begin
                                s = a + b;
                                if (((a ^ s) & (b ^ s)) >> 31) stop(mrc_pkg::HALT_OVERFLOW);
                                else begin wr_reg = rd; wr_val = s; end
                            end
                            FN_ADDU: begin wr_reg = rd; wr_val = a + b; end
                            FN_SUBU: begin wr_reg = rd; wr_val = a - b; end
                            FN_AND:  begin wr_reg = rd; wr_val = a & b; end
                            FN_OR:   begin wr_reg = rd; wr_val = a | b; end
                            FN_SLTU: begin wr_reg = rd; wr_val = {31'd0, a < b}; end
                            default: stop(mrc_pkg::HALT_UNHANDLED);
                        endcase
                    end
                    OP_REGIMM: begin
                        if (ins[20]) begin wr_reg = mrc_pkg::LINK_IDX; wr_val = pc; end
                        if (ins[16] ? !a[31] : a[31]) pc = pc - 32'd4 + (simm << 2);
                    end
                    OP_J, OP_JAL: begin
                        if (op == OP_JAL) begin wr_reg = mrc_pkg::LINK_IDX; wr_val = pc; end
                        pc = ((pc - 32'd4) & 32'hF000_0000) + {4'd0, ins[25:0], 2'b00};
                    end
                    OP_BEQ:  if (a == b) pc = pc - 32'd4 + (simm << 2);
                    OP_BNE:  if (a != b) pc = pc - 32'd4 + (simm << 2);
                    OP_BLEZ: if (a[31] || a == 0) pc = pc - 32'd4 + (simm << 2);
                    OP_BGTZ: if (!a[31] && a != 0) pc = pc - 32'd4 + (simm << 2);
                    OP_ADDI: begin
                        s = a + simm;
                        if (((a ^ s) & (simm ^ s)) >> 31) stop(mrc_pkg::HALT_OVERFLOW);
                        else begin wr_reg = rt; wr_val = s; end
                    end
                    OP_ADDIU: begin wr_reg = rt; wr_val = a + simm; end
                    OP_SLTI: begin wr_reg = rt; wr_val = {31'd0, $signed(a) < $signed(simm)}; end
                    OP_ANDI: begin wr_reg = rt; wr_val = a & {16'd0, ins[15:0]}; end
                    OP_ORI:  begin wr_reg = rt; wr_val = a | {16'd0, ins[15:0]}; end
                    OP_LUI:  begin wr_reg = rt; wr_val = {ins[15:0], 16'd0}; end
                    OP_COP0: begin
                        if (rs == CP_MT || rs == CP_MF) begin
                            if (ins[1:0] != 0) stop(mrc_pkg::HALT_COPROC);
                            else if (rs == CP_MT) begin
                                if (rd != 0) begin
                                    cop0[rd] = b;
                                    if (b != 0 && rd inside {3, 5, 6, 7, 9, 11})
                                        stop(mrc_pkg::HALT_PROTECT);
                                end
                            end else begin
                                dl_tgt = rt;
                                dl_val = cop0[rd];
                            end
                        end else begin
                            pc = pc - 32'd4;
                            stop(mrc_pkg::HALT_UNHANDLED);
                        end
                    end
                    OP_LB, OP_LW, OP_LBU: begin
                        r.mem_request = mrc_pkg::REQ_READ;
                        r.mem_address = a + simm;
                        r.mem_size = (op == OP_LW) ? mrc_pkg::SIZE_WORD : mrc_pkg::SIZE_BYTE;
                        ld_busy = 1'b1;
                        ld_kind = (op == OP_LB) ? mrc_pkg::LD_LB :
                                  ((op == OP_LBU) ? mrc_pkg::LD_LBU : mrc_pkg::LD_LW);
                        ld_tgt = rt;
                    end
                    OP_SB, OP_SH, OP_SW: begin
                        r.mem_request = mrc_pkg::REQ_WRITE;
                        r.mem_address = a + simm;
                        if (op == OP_SB) begin
                            r.mem_size = mrc_pkg::SIZE_BYTE;
                            r.mem_write_data = {24'd0, b[7:0]};
                        end else if (op == OP_SH) begin
                            r.mem_size = mrc_pkg::SIZE_HALF;
                            r.mem_write_data = {16'd0, b[15:0]};
                        end else begin
                            r.mem_size = mrc_pkg::SIZE_WORD;
                            r.mem_write_data = b;
                        end
                        r.status_word = cop0[mrc_pkg::STATUS_IDX];
                    end
                    default: begin
                        pc = pc - 32'd4;
                        stop(mrc_pkg::HALT_UNHANDLED);
                    end
                endcase
                // own write wins over a load landing on the same register
                if (wr_reg != 0) gpr[wr_reg] = wr_val;
            end
            r.fetch_address = pc;
            r.halt_cause = cause;
            return r;
        endfunction

        function void note_transaction(mrc_pkg::in_item_t it);
            pending_results.push_back(execute_item(it));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_transaction(mrc_pkg::out_item_t got);
            mrc_pkg::out_item_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("fetch_address", want.fetch_address, got.fetch_address);
            compare_field("mem_request", 32'(want.mem_request), 32'(got.mem_request));
            compare_field("mem_address", want.mem_address, got.mem_address);
            compare_field("mem_size", 32'(want.mem_size), 32'(got.mem_size));
            compare_field("mem_write_data", want.mem_write_data, got.mem_write_data);
            compare_field("status_word", want.status_word, got.status_word);
            compare_field("halt_cause", 32'(want.halt_cause), 32'(got.halt_cause));
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    mrc_pkg::in_item_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    mrc_pkg::out_item_t m_data;

    core_result_board board = new();

    int send_idle_pct = 10;
    int recv_idle_pct = 49;
    bit hold_request = 1'b0;
    int stall_count = 0;

    mips_r3000_subset_core_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Result side: random back-pressure, with a long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_transaction(m_data);
    end

    // Watchdog: count cycles in which no transaction moves on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Offer one transaction, hold it until accepted, then log it.
    task automatic send_item(mrc_pkg::in_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_transaction(it);
    endtask

    task automatic send_instr(logic [31:0] w);
        mrc_pkg::in_item_t it;
        it.opcode = mrc_pkg::KIND_INSTR;
        it.instruction_word = w;
        it.load_data = $urandom;
        send_item(it);
    endtask

    task automatic send_load_data(logic [31:0] d);
        mrc_pkg::in_item_t it;
        it.opcode = mrc_pkg::KIND_LOAD;
        it.instruction_word = $urandom;
        it.load_data = d;
        send_item(it);
    endtask

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_cop0(logic [4:0] sel, logic [4:0] rt, logic [4:0] rd);
        return {OP_COP0, sel, rt, rd, 11'd0};
    endfunction

    function automatic bit is_load(logic [31:0] w);
        return w[31:26] inside {OP_LB, OP_LW, OP_LBU};
    endfunction

    // A random instruction that keeps the core running: ADD and ADDI read r0
    // on one side so they cannot overflow, MTC0 skips the protected registers.
    function automatic logic [31:0] random_instr();
        logic [4:0]  rs, rt, rd, sh;
        logic [15:0] imm;
        logic [31:0] w;
        rs = 5'($urandom);
        rt = 5'($urandom);
        rd = 5'($urandom);
        sh = 5'($urandom);
        imm = 16'($urandom);
        case ($urandom_range(27))
            0:  w = enc_r(FN_SLL, rs, rt, rd, sh);
            1:  w = enc_r(FN_SRA, rs, rt, rd, sh);
            2:  w = enc_r(FN_JR, rs, 5'd0, 5'd0, 5'd0);
            3:  w = enc_r(FN_JALR, rs, 5'd0, rd, 5'd0);
            4:  w = $urandom_range(1) ? enc_r(FN_ADD, 5'd0, rt, rd, sh)
                                      : enc_r(FN_ADD, rs, 5'd0, rd, sh);
            5:  w = enc_r(FN_ADDU, rs, rt, rd, sh);
            6:  w = enc_r(FN_SUBU, rs, rt, rd, sh);
            7:  w = enc_r(FN_AND, rs, rt, rd, sh);
            8:  w = enc_r(FN_OR, rs, rt, rd, sh);
            9:  w = enc_r(FN_SLTU, rs, rt, rd, sh);
            10: w = enc_i(OP_REGIMM, rs,
                          {1'($urandom_range(1)), 3'd0, 1'($urandom_range(1))}, imm);
            11: w = {OP_J, 26'($urandom)};
            12: w = {OP_JAL, 26'($urandom)};
            13: w = enc_i(OP_BEQ, rs, rt, imm);
            14: w = enc_i(OP_BNE, rs, rt, imm);
            15: w = enc_i(OP_BLEZ, rs, rt, imm);
            16: w = enc_i(OP_BGTZ, rs, rt, imm);
            17: w = enc_i(OP_ADDI, 5'd0, rt, imm);
            18: w = enc_i(OP_ADDIU, rs, rt, imm);
            19: w = enc_i(OP_SLTI, rs, rt, imm);
            20: w = enc_i(OP_ANDI, rs, rt, imm);
            21: w = enc_i(OP_ORI, rs, rt, imm);
            22: w = enc_i(OP_LUI, rs, rt, imm);
            23: begin
                if (rd inside {3, 5, 6, 7, 9, 11} || $urandom_range(2) == 0) begin
                    rd = mrc_pkg::STATUS_IDX;
                end
                w = enc_cop0(CP_MT, rt, rd);
            end
            24: w = enc_cop0(CP_MF, rt, rd);
            25, 26: begin
                case ($urandom_range(2))
                    0: w = enc_i(OP_LB, rs, rt, imm);
                    1: w = enc_i(OP_LBU, rs, rt, imm);
                    default: w = enc_i(OP_LW, rs, rt, imm);
                endcase
            end
            default: begin
                case ($urandom_range(2))
                    0: w = enc_i(OP_SB, rs, rt, imm);
                    1: w = enc_i(OP_SH, rs, rt, imm);
                    default: w = enc_i(OP_SW, rs, rt, imm);
                endcase
            end
        endcase
        return w;
    endfunction

    // Send an instruction; when the word now executing is a load, follow
    // with its return data most of the time, as a memory would.
    task automatic issue(logic [31:0] w, ref logic [31:0] last_word, input logic [31:0] d);
        send_instr(w);
        if (is_load(last_word) && $urandom_range(9) != 0) send_load_data(d);
        last_word = w;
    endtask

    task automatic run_random(int count, ref logic [31:0] last_word);
        for (int n = 0; n < count; n++) begin
            if (n == count / 3 && recv_idle_pct > 0 && recv_idle_pct < 40) hold_request = 1'b1;
            // stray return data, whether or not a load is outstanding
            if ($urandom_range(99) < 3) send_load_data($urandom);
            issue(random_instr(), last_word, $urandom);
        end
    endtask

    // Hold the sender until every result is back, then let the core settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_boot_pc(logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.load_boot_pc(v);
    endtask

    initial begin
        logic [31:0] directed[$];
        logic [31:0] ld_values[3];
        logic [31:0] last_word;
        int          k;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: operand extremes, each non-halting operation, load delay and sign
        // extension, link on branch, store size truncation with status.
        directed = '{
            enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF),
            enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF),
            enc_i(OP_ADDIU, 5'd0, 5'd2, 16'h8000),
            enc_i(OP_LUI, 5'd0, 5'd3, 16'h7FFF),
            enc_r(FN_ADDU, 5'd1, 5'd3, 5'd4, 5'd0),
            enc_r(FN_SUBU, 5'd0, 5'd1, 5'd5, 5'd0),
            enc_r(FN_AND, 5'd1, 5'd3, 5'd6, 5'd0),
            enc_r(FN_OR, 5'd2, 5'd3, 5'd7, 5'd0),
            enc_r(FN_SLTU, 5'd2, 5'd1, 5'd8, 5'd0),
            enc_i(OP_SLTI, 5'd1, 5'd9, 16'h7FFF),
            enc_i(OP_ANDI, 5'd1, 5'd10, 16'hFFFF),
            enc_r(FN_SLL, 5'd0, 5'd1, 5'd11, 5'd31),
            enc_r(FN_SRA, 5'd0, 5'd2, 5'd12, 5'd31),
            enc_r(FN_ADD, 5'd0, 5'd3, 5'd13, 5'd0),
            enc_i(OP_ADDI, 5'd0, 5'd14, 16'h8000),
            enc_cop0(CP_MT, 5'd1, mrc_pkg::STATUS_IDX),
            enc_cop0(CP_MF, 5'd15, mrc_pkg::STATUS_IDX),
            enc_r(FN_ADDU, 5'd15, 5'd0, 5'd16, 5'd0),
            enc_i(OP_SB, 5'd2, 5'd1, 16'h7FFF),
            enc_i(OP_SH, 5'd0, 5'd1, 16'h8000),
            enc_i(OP_SW, 5'd1, 5'd1, 16'hFFFF),
            enc_i(OP_LB, 5'd0, 5'd17, 16'h0004),
            enc_r(FN_ADDU, 5'd17, 5'd0, 5'd18, 5'd0),
            enc_i(OP_LBU, 5'd0, 5'd17, 16'h0008),
            enc_i(OP_LW, 5'd0, 5'd17, 16'h000C),
            enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0004),
            enc_i(OP_BNE, 5'd1, 5'd0, 16'hFFFF),
            enc_i(OP_BLEZ, 5'd1, 5'd0, 16'h8000),
            enc_i(OP_BGTZ, 5'd3, 5'd0, 16'h7FFF),
            enc_i(OP_REGIMM, 5'd3, 5'h11, 16'h0010),
            enc_i(OP_REGIMM, 5'd1, 5'h10, 16'h0010),
            {OP_J, 26'h3FF_FFFF},
            {OP_JAL, 26'h000_0000},
            enc_r(FN_JR, 5'd3, 5'd0, 5'd0, 5'd0),
            enc_r(FN_JALR, 5'd1, 5'd0, 5'd31, 5'd0)
        };
        ld_values = '{32'h0000_0080, 32'hFFFF_FF7F, 32'hFFFF_FFFF};
        last_word = '0;
        k = 0;
        foreach (directed[i]) begin
            if (is_load(last_word)) begin
                send_instr(directed[i]);
                send_load_data(ld_values[k % 3]);
                k++;
                last_word = directed[i];
            end else begin
                issue(directed[i], last_word, 32'h0);
            end
        end

        // Phase 1: sender idles lightly, receiver heavily; lowest boot PC.
        drain();
        write_boot_pc(32'h0000_0000);
        run_random(560, last_word);

        // Phase 2: roles swapped, long receiver hold-off included; top boot PC.
        drain();
        send_idle_pct = 49;
        recv_idle_pct = 10;
        write_boot_pc(32'hFFFF_FFFF);
        run_random(560, last_word);

        // Phase 3: back to back; random boot PC.
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_boot_pc($urandom);
        run_random(560, last_word);

        // Close with one halt of a random kind, then show it is sticky.
        case ($urandom_range(4))
            0: send_instr({OP_COP1, 26'($urandom)});
            1: begin
                send_instr(enc_i(OP_LUI, 5'd0, 5'd20, 16'h7FFF));
                send_instr(enc_r(FN_ADD, 5'd20, 5'd20, 5'd21, 5'd0));
            end
            2: send_instr({OP_COP0, CP_MT, 5'd0, 5'd0, 9'd0, 2'b01});
            3: begin
                send_instr(enc_i(OP_ORI, 5'd0, 5'd20, 16'h0001));
                send_instr(enc_cop0(CP_MT, 5'd20, 5'd3));
            end
            default: send_instr(enc_r(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0));
        endcase
        send_instr({OP_BAD, 26'($urandom)});
        repeat (4) send_instr($urandom);
        send_load_data($urandom);

        drain();
        repeat (6) @(posedge aclk);
        if (board.errors == 0 && board.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
